// ----- src/ldl_pkg.sv -----
// shared constants, types and helpers for the ldl factorization block
package ldl_pkg;

  localparam int MAX_SIZE  = 8;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 4;
  localparam int IDX_W     = $clog2(MAX_SIZE);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_SIZE * MAX_SIZE;
  localparam int QUO_W     = DATA_W + FRAC_BITS;
  localparam int PROD_W    = 2 * DATA_W;

  localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [IDX_W-1:0]         idx_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_INIT_W,
    ST_RDX,
    ST_RDY,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_ACC,
    ST_FIN,
    ST_DIV,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_e;

  // saturating difference a - b
  function automatic word_t sat_sub(word_t a, word_t b);
    logic signed [DATA_W:0] d;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (d[DATA_W] != d[DATA_W-1]) begin
      sat_sub = d[DATA_W] ? SMIN : SMAX;
    end else begin
      sat_sub = d[DATA_W-1:0];
    end
  endfunction

  // order in use minus one, with out-of-range sizes clamped
  function automatic idx_t size_to_last(logic [CFG_W-1:0] s);
    if (s == '0) begin
      size_to_last = '0;
    end else if (int'(s) > MAX_SIZE) begin
      size_to_last = IDX_W'(MAX_SIZE - 1);
    end else begin
      size_to_last = IDX_W'(s - CFG_W'(1));
    end
  endfunction

endpackage

// ----- src/ldl_in_if.sv -----
// input channel: one matrix entry per transfer
interface ldl_in_if import ldl_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t entry_value;

  modport source (output valid, output entry_value, input ready);
  modport sink (input valid, input entry_value, output ready);
endinterface

// ----- src/ldl_out_if.sv -----
// output channel: one factor entry per transfer
interface ldl_out_if import ldl_pkg::*; ();
  logic  valid;
  logic  ready;
  idx_t  row_index;
  idx_t  col_index;
  word_t factor_value;
  logic  is_pivot;
  logic  singular;
  logic  last_out;

  modport source (output valid, output row_index, output col_index, output factor_value,
                  output is_pivot, output singular, output last_out, input ready);
  modport sink (input valid, input row_index, input col_index, input factor_value,
                input is_pivot, input singular, input last_out, output ready);
endinterface

// ----- src/ldl_mul.sv -----
// shared fixed-point multiplier: registered product, floor shift and saturate
module ldl_mul import ldl_pkg::*; (
  input  logic  clk_i,
  input  word_t a_i,
  input  word_t b_i,
  output word_t res_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] shifted;
  logic [PROD_W-DATA_W:0]   hi_bits;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign shifted = prod_q >>> FRAC_BITS;
  assign hi_bits = shifted[PROD_W-1:DATA_W-1];

  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      res_o = shifted[DATA_W-1:0];
    end else begin
      res_o = shifted[PROD_W-1] ? SMIN : SMAX;
    end
  end

endmodule

// ----- src/ldl_div.sv -----
// radix-2 restoring divider for (num << FRAC_BITS) / den, truncating and saturating
module ldl_div import ldl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t num_i,
  input  word_t den_i,
  output logic  busy_o,
  output word_t quo_o
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [QUO_W-1:0] dvd_q, dvd_d;
  logic [DATA_W:0]  rem_q, rem_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [DATA_W:0]  rem_sh;
  logic             fits;
  logic [DATA_W-1:0] abs_num, abs_den;

  assign abs_num = num_i[DATA_W-1] ? DATA_W'(-num_i) : DATA_W'(num_i);
  assign abs_den = den_i[DATA_W-1] ? DATA_W'(-den_i) : DATA_W'(den_i);
  assign rem_sh  = {rem_q[DATA_W-1:0], dvd_q[QUO_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUO_W);
      dvd_d  = {abs_num, {FRAC_BITS{1'b0}}};
      rem_d  = '0;
      dvs_d  = abs_den;
      neg_d  = num_i[DATA_W-1] ^ den_i[DATA_W-1];
    end else if (busy_q) begin
      // quotient bits shift in where dividend bits leave
      rem_d = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      dvd_d = {dvd_q[QUO_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  always_comb begin
    if (|dvd_q[QUO_W-1:DATA_W-1]) begin
      quo_o = neg_q ? SMIN : SMAX;
    end else if (neg_q) begin
      quo_o = -word_t'(dvd_q[DATA_W-1:0]);
    end else begin
      quo_o = word_t'(dvd_q[DATA_W-1:0]);
    end
  end

  assign busy_o = busy_q;

endmodule

// ----- src/ldl_decomposition_core.sv -----
// ldl^t factorization of a symmetric q16.16 matrix: load, factor, emit
//
//   channel  dir  fields                                                  transfer when
//   in_i     in   entry_value                                             valid & ready
//   out_o    out  row_index col_index factor_value is_pivot singular last  valid & ready
//   cfg      in   cfg_wdata_i (matrix_size)                               cfg_we_i
//
// each entry loads on a valid and ready transfer; the last entry of an n x n matrix starts factoring
// factoring takes, per column i, i*(n-i) multiply-accumulate terms and one division per
// strictly lower entry (n*(n-1)/2 of them, skipped for a zero pivot), all on
// one multiplier and one bit-serial divider
// results go out one at a time, each held until it transfers; input is not ready
// from the last entry until the final result transfers
// reset is asynchronous and leaves size 8 and an empty load; stores are not cleared
module ldl_decomposition_core import ldl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  ldl_in_if.sink           in_i,
  ldl_out_if.source        out_o
);

  state_e state_q, state_d;
  idx_t   last_q, last_d;
  idx_t   r_q, r_d, c_q, c_d;
  idx_t   i_q, i_d, j_q, j_d, k_q, k_d;
  word_t  acc_q, acc_d;
  word_t  x_q, x_d, y_q, y_d, t_q, t_d, d_q, d_d;
  logic   sing_q, sing_d;

  idx_t   out_row_q, out_row_d, out_col_q, out_col_d;
  word_t  out_val_q, out_val_d;
  logic   out_piv_q, out_piv_d, out_sing_q, out_sing_d, out_last_q, out_last_d;

  // matrix store, one write and one registered read per cycle
  word_t             mem_q [DEPTH];
  word_t             rd_data_q;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  word_t             wdata;

  // pivot store, read at one address at a time
  word_t pivot_q [MAX_SIZE];
  logic  piv_we;
  idx_t  piv_raddr;
  word_t piv_rd;

  word_t mul_a, mul_b, mul_res;
  logic  div_start, div_busy;
  word_t div_quo;
  logic  pivot_mode;
  logic  in_xfer, out_xfer;

  ldl_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  ldl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q),
    .den_i   (d_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign pivot_mode = (j_q == i_q);
  assign in_i.ready = (state_q == ST_LOAD);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;
  assign piv_raddr  = (state_q == ST_EMIT_LD) ? i_q : k_q;
  assign piv_rd     = pivot_q[piv_raddr];

  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    r_d        = r_q;
    c_d        = c_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    acc_d      = acc_q;
    x_d        = x_q;
    y_d        = y_q;
    t_d        = t_q;
    d_d        = d_q;
    sing_d     = sing_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_val_d  = out_val_q;
    out_piv_d  = out_piv_q;
    out_sing_d = out_sing_q;
    out_last_d = out_last_q;
    we         = 1'b0;
    waddr      = {j_q, i_q};
    wdata      = div_quo;
    raddr      = {j_q, i_q};
    piv_we     = 1'b0;
    mul_a      = x_q;
    mul_b      = x_q;
    div_start  = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          // only the diagonal and lower triangle are kept
          we    = (c_q <= r_q);
          waddr = {r_q, c_q};
          wdata = in_i.entry_value;
          if (c_q == last_q) begin
            c_d = '0;
            if (r_q == last_q) begin
              r_d     = '0;
              i_d     = '0;
              j_d     = '0;
              state_d = ST_INIT;
            end else begin
              r_d = r_q + IDX_W'(1);
            end
          end else begin
            c_d = c_q + IDX_W'(1);
          end
        end
      end
      ST_INIT: begin
        raddr   = {j_q, i_q};
        k_d     = '0;
        state_d = ST_INIT_W;
      end
      ST_INIT_W: begin
        acc_d   = rd_data_q;
        state_d = (i_q == '0) ? ST_FIN : ST_RDX;
      end
      ST_RDX: begin
        raddr   = {j_q, k_q};
        state_d = ST_RDY;
      end
      ST_RDY: begin
        x_d     = rd_data_q;
        raddr   = {i_q, k_q};
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        // pivot term is d[k]*(l*l), off-diagonal term is (d[k]*l[j][k])*l[i][k]
        y_d     = rd_data_q;
        mul_a   = pivot_mode ? x_q : piv_rd;
        mul_b   = x_q;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        t_d     = mul_res;
        state_d = ST_MUL3;
      end
      ST_MUL3: begin
        mul_a   = pivot_mode ? piv_rd : t_q;
        mul_b   = pivot_mode ? t_q : y_q;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d = sat_sub(acc_q, mul_res);
        if (k_q == i_q - IDX_W'(1)) begin
          state_d = ST_FIN;
        end else begin
          k_d     = k_q + IDX_W'(1);
          state_d = ST_RDX;
        end
      end
      ST_FIN: begin
        if (pivot_mode) begin
          piv_we = 1'b1;
          d_d    = acc_q;
          if (i_q == last_q) begin
            i_d     = '0;
            k_d     = '0;
            sing_d  = 1'b0;
            state_d = ST_EMIT_RD;
          end else begin
            j_d     = i_q + IDX_W'(1);
            state_d = ST_INIT;
          end
        end else if (d_q == '0) begin
          // zero pivot zeroes the whole column below it
          we    = 1'b1;
          wdata = '0;
          if (j_q == last_q) begin
            i_d = i_q + IDX_W'(1);
            j_d = i_q + IDX_W'(1);
          end else begin
            j_d = j_q + IDX_W'(1);
          end
          state_d = ST_INIT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          we    = 1'b1;
          wdata = div_quo;
          if (j_q == last_q) begin
            i_d = i_q + IDX_W'(1);
            j_d = i_q + IDX_W'(1);
          end else begin
            j_d = j_q + IDX_W'(1);
          end
          state_d = ST_INIT;
        end
      end
      ST_EMIT_RD: begin
        raddr   = {i_q, k_q};
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_row_d  = i_q;
        out_col_d  = k_q;
        out_piv_d  = (k_q == i_q);
        out_last_d = (k_q == i_q) && (i_q == last_q);
        if (k_q == i_q) begin
          out_val_d  = piv_rd;
          out_sing_d = sing_q || (piv_rd == '0);
          sing_d     = sing_q || (piv_rd == '0);
        end else begin
          out_val_d  = rd_data_q;
          out_sing_d = sing_q;
        end
        state_d = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_xfer) begin
          if (k_q == i_q) begin
            if (i_q == last_q) begin
              state_d = ST_LOAD;
            end else begin
              i_d     = i_q + IDX_W'(1);
              k_d     = '0;
              state_d = ST_EMIT_RD;
            end
          end else begin
            k_d     = k_q + IDX_W'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // size write restarts the load
    if (cfg_we_i) begin
      last_d = size_to_last(cfg_wdata_i);
      r_d    = '0;
      c_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      last_q  <= IDX_W'(MAX_SIZE - 1);
      r_q     <= '0;
      c_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      sing_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      r_q     <= r_d;
      c_q     <= c_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      sing_q  <= sing_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    x_q        <= x_d;
    y_q        <= y_d;
    t_q        <= t_d;
    d_q        <= d_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_val_q  <= out_val_d;
    out_piv_q  <= out_piv_d;
    out_sing_q <= out_sing_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_data_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (piv_we) begin
      pivot_q[i_q] <= acc_q;
    end
  end

  assign out_o.valid        = (state_q == ST_EMIT_WAIT);
  assign out_o.row_index    = out_row_q;
  assign out_o.col_index    = out_col_q;
  assign out_o.factor_value = out_val_q;
  assign out_o.is_pivot     = out_piv_q;
  assign out_o.singular     = out_sing_q;
  assign out_o.last_out     = out_last_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result is pending");

  a_last_is_pivot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last_out |-> out_o.is_pivot && (out_o.row_index == last_q))
    else $error("final result is not the last pivot");

  a_lower_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.is_pivot |-> out_o.col_index < out_o.row_index)
    else $error("l entry outside the strict lower triangle");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy && (d_q != '0))
    else $error("divider started while busy or with a zero pivot");

  a_sing_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_o.singular && !out_o.last_out |=> sing_q)
    else $error("singular flag dropped within a factorization");

endmodule

// ----- dv/ldl_decomposition_core_tb.sv -----
// testbench for the ldl factorization core: predicting scoreboard, stimulus and checks
`timescale 1ns / 100ps

module ldl_decomposition_core_tb;
  import ldl_pkg::*;

  localparam int          TOTAL_ENTRIES = 460;
  localparam int          CALM_AFTER    = 380;
  localparam int          HOLD_CYCLES   = 600;
  localparam int          QUIET_LIMIT   = 20000;
  localparam int          TAIL_CYCLES   = 64;
  localparam int          SETTLE_CYCLES = 16;
  localparam logic [CFG_W-1:0] SIZE_MIN  = 1;
  localparam logic [CFG_W-1:0] SIZE_FULL = 8;
  localparam logic [CFG_W-1:0] SIZE_ZERO = 0;
  localparam logic [CFG_W-1:0] SIZE_TOP  = '1;
  localparam word_t       ONE_Q = 32'sh0001_0000;
  localparam word_t       LSB_Q = 32'sh0000_0001;

  typedef enum int {FILL_SPD, FILL_SMALL, FILL_WILD, FILL_EDGE} fill_e;

  typedef struct packed {
    idx_t  row_index;
    idx_t  col_index;
    word_t factor_value;
    logic  is_pivot;
    logic  singular;
    logic  last_out;
  } factor_t;

  class ldl_scoreboard;
    word_t            mat[DEPTH];
    word_t            piv[MAX_SIZE];
    int unsigned      loaded;
    logic [CFG_W-1:0] size_reg;
    factor_t          pending[$];
    int               errors;
    int               entries;
    int               results;
    int               matrices;
    int               singular_mats;

    function new();
      loaded        = 0;
      size_reg      = SIZE_FULL;
      errors        = 0;
      entries       = 0;
      results       = 0;
      matrices      = 0;
      singular_mats = 0;
    endfunction

    function word_t clamp32(longint v);
      if (v > longint'(SMAX)) return SMAX;
      if (v < longint'(SMIN)) return SMIN;
      return word_t'(v[DATA_W-1:0]);
    endfunction

    // floor of the q product, then saturate
    function word_t mul_q(word_t a, word_t b);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp32(p >>> FRAC_BITS);
    endfunction

    function word_t sub_q(word_t a, word_t b);
      return clamp32(longint'(a) - longint'(b));
    endfunction

    // sv division truncates toward zero
    function word_t div_q(word_t num, word_t den);
      longint w;
      w = longint'(num) * (longint'(1) << FRAC_BITS);
      return clamp32(w / longint'(den));
    endfunction

    function int unsigned order_in_use();
      if (size_reg == SIZE_ZERO) return 1;
      if (int'(size_reg) > MAX_SIZE) return MAX_SIZE;
      return int'(size_reg);
    endfunction

    function void set_size(logic [CFG_W-1:0] v);
      size_reg = v;
      loaded   = 0;
    endfunction

    function void factor_and_queue(int unsigned n);
      word_t   acc;
      word_t   s;
      word_t   t;
      factor_t f;
      logic    sing;
      for (int unsigned i = 0; i < n; i++) begin
        acc = mat[i*MAX_SIZE+i];
        for (int unsigned k = 0; k < i; k++) begin
          acc = sub_q(acc, mul_q(piv[k], mul_q(mat[i*MAX_SIZE+k], mat[i*MAX_SIZE+k])));
        end
        piv[i] = acc;
        for (int unsigned j = i + 1; j < n; j++) begin
          s = mat[j*MAX_SIZE+i];
          for (int unsigned k = 0; k < i; k++) begin
            t = mul_q(piv[k], mat[j*MAX_SIZE+k]);
            s = sub_q(s, mul_q(t, mat[i*MAX_SIZE+k]));
          end
          // zero pivot zeroes its whole l column
          mat[j*MAX_SIZE+i] = (acc == 0) ? word_t'(0) : div_q(s, acc);
        end
      end
      sing = 1'b0;
      for (int unsigned i = 0; i < n; i++) begin
        for (int unsigned k = 0; k < i; k++) begin
          f.row_index    = idx_t'(i);
          f.col_index    = idx_t'(k);
          f.factor_value = mat[i*MAX_SIZE+k];
          f.is_pivot     = 1'b0;
          f.singular     = sing;
          f.last_out     = 1'b0;
          pending.push_back(f);
        end
        if (piv[i] == 0) sing = 1'b1;
        f.row_index    = idx_t'(i);
        f.col_index    = idx_t'(i);
        f.factor_value = piv[i];
        f.is_pivot     = 1'b1;
        f.singular     = sing;
        f.last_out     = (i + 1 == n);
        pending.push_back(f);
      end
      matrices++;
      if (sing) singular_mats++;
    endfunction

    function void note_entry(word_t v);
      int unsigned n;
      int unsigned r;
      int unsigned c;
      n = order_in_use();
      r = loaded / n;
      c = loaded % n;
      entries++;
      if (r < n && c <= r) mat[r*MAX_SIZE+c] = v;
      loaded++;
      if (loaded == n * n) begin
        loaded = 0;
        factor_and_queue(n);
      end
    endfunction

    function void check_result(factor_t got);
      factor_t want;
      if (pending.size() == 0) begin
        $error("unexpected factor result: row %0d col %0d value %0d",
               got.row_index, got.col_index, got.factor_value);
        errors++;
        return;
      end
      want = pending.pop_front();
      results++;
      if (got.row_index != want.row_index) begin
        $error("row_index: expected %0d, actual %0d", want.row_index, got.row_index);
        errors++;
      end
      if (got.col_index != want.col_index) begin
        $error("col_index: expected %0d, actual %0d", want.col_index, got.col_index);
        errors++;
      end
      if (got.factor_value !== want.factor_value) begin
        $error("factor_value: expected %0d, actual %0d", want.factor_value, got.factor_value);
        errors++;
      end
      if (got.is_pivot !== want.is_pivot) begin
        $error("is_pivot: expected %0b, actual %0b", want.is_pivot, got.is_pivot);
        errors++;
      end
      if (got.singular !== want.singular) begin
        $error("singular: expected %0b, actual %0b", want.singular, got.singular);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0b, actual %0b", want.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             idle_on;
  int               hold_tickets;

  ldl_in_if  in_ch();
  ldl_out_if out_ch();

  ldl_decomposition_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  ldl_scoreboard sb = new();

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic word_t make_entry(fill_e kind, int unsigned r, int unsigned c,
                                       int unsigned n);
    int unsigned pick;
    // upper triangle is ignored by the block
    if (c > r) return word_t'($urandom());
    case (kind)
      FILL_SPD: begin
        if (r == c) return word_t'((n << FRAC_BITS) + $urandom_range(0, 1 << 18));
        return word_t'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
      end
      FILL_SMALL: begin
        return word_t'((int'($urandom_range(0, 6)) - 3) * (1 << FRAC_BITS));
      end
      FILL_EDGE: begin
        pick = $urandom_range(0, 6);
        case (pick)
          0: return SMAX;
          1: return SMIN;
          2: return word_t'(0);
          3: return ONE_Q;
          4: return -ONE_Q;
          5: return LSB_Q;
          default: return -LSB_Q;
        endcase
      end
      default: return word_t'($urandom());
    endcase
  endfunction

  task automatic send_entry(input word_t v);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.entry_value <= v;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_entry(v);
  endtask

  // size writes only once all results are out and the block has settled
  task automatic write_size(input logic [CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_size(v);
    cfg_we_i <= 1'b0;
  endtask

  // result side: random stall bursts plus the long hold-off on request
  initial begin : result_sink
    int stall_left;
    int holds_taken;
    factor_t got;
    stall_left   = 0;
    holds_taken  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got.row_index    = out_ch.row_index;
        got.col_index    = out_ch.col_index;
        got.factor_value = out_ch.factor_value;
        got.is_pivot     = out_ch.is_pivot;
        got.singular     = out_ch.singular;
        got.last_out     = out_ch.last_out;
        sb.check_result(got);
      end
      if (hold_tickets != holds_taken) begin
        holds_taken++;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] sz;
    int unsigned      n;
    int unsigned      mats;
    int unsigned      part;
    int unsigned      pick;
    fill_e            kind;
    int               phase;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.entry_value <= '0;
    idle_on           <= 1'b1;
    hold_tickets      <= 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single entry: zero pivot, then both saturation extremes
    write_size(SIZE_MIN);
    send_entry(word_t'(0));
    send_entry(SMAX);
    send_entry(SMIN);
    // size zero behaves as order one
    write_size(SIZE_ZERO);
    send_entry(ONE_Q);
    // zero leading pivot zeroes the l column and raises singular
    write_size(CFG_W'(2));
    send_entry(word_t'(0));
    send_entry(SMAX);
    send_entry(5 * ONE_Q);
    send_entry(7 * ONE_Q);
    send_entry(SMIN);
    send_entry(word_t'(0));
    send_entry(SMAX);
    send_entry(SMIN);
    // size write mid-load restarts the load
    write_size(CFG_W'(3));
    send_entry(ONE_Q);
    send_entry(-ONE_Q);
    send_entry(SMAX);
    send_entry(3 * ONE_Q);
    write_size(CFG_W'(2));
    send_entry(LSB_Q);
    send_entry(SMIN);
    send_entry(SMIN);
    send_entry(SMAX);

    phase = 0;
    while (sb.entries < TOTAL_ENTRIES) begin
      if (phase == 0) begin
        sz = SIZE_TOP;
      end else if (phase == 1) begin
        sz = SIZE_FULL;
      end else if (phase == 2) begin
        sz = CFG_W'(3);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60)      sz = CFG_W'($urandom_range(1, 4));
        else if (pick < 82) sz = CFG_W'($urandom_range(5, 7));
        else if (pick < 88) sz = SIZE_FULL;
        else if (pick < 94) sz = CFG_W'($urandom_range(9, 15));
        else                sz = SIZE_ZERO;
      end
      write_size(sz);
      idle_on <= (sb.entries < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      n    = sb.order_in_use();
      mats = (n >= MAX_SIZE) ? 1 : $urandom_range(1, 3);
      if (phase == 2) begin
        // results get held back while the next matrix keeps pressing on the input
        mats = 3;
        hold_tickets <= hold_tickets + 1;
      end
      for (int unsigned m = 0; m < mats; m++) begin
        kind = fill_e'($urandom_range(0, 3));
        for (int unsigned e = 0; e < n * n; e++) begin
          send_entry(make_entry(kind, e / n, e % n, n));
        end
      end
      // now and then leave a load unfinished before the next size write
      if (n > 1 && $urandom_range(0, 7) == 0) begin
        part = $urandom_range(1, n * n - 1);
        for (int unsigned e = 0; e < part; e++) begin
          send_entry(make_entry(FILL_WILD, e / n, e % n, n));
        end
      end
      phase++;
    end

    idle_on     <= 1'b0;
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("run covered %0d entries over %0d size settings, %0d matrices factored",
             sb.entries, phase + 5, sb.matrices);
    $display("%0d factor results checked, %0d matrices with a zero pivot",
             sb.results, sb.singular_mats);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/ldl_pkg.sv
src/ldl_in_if.sv
src/ldl_out_if.sv
src/ldl_mul.sv
src/ldl_div.sv
src/ldl_decomposition_core.sv
dv/ldl_decomposition_core_tb.sv
